[hdl/frm_pkg.sv]
// Shared constants and types of the frame rate meter.
// No dependencies; used by every module of the block.
package frm_pkg;

	localparam int WORD_WIDTH     = 32;
	localparam int RATE_WIDTH     = 16;
	localparam int CFG_WIDTH      = 16;
	localparam int ACC_CNT_WIDTH  = $clog2(WORD_WIDTH);
	localparam int DIV_STEP_WIDTH = $clog2(WORD_WIDTH + 1);

	localparam int MS_PER_S    = 1000;
	localparam int MS_DIV_BITS = 10;
	localparam logic [WORD_WIDTH-1:0] MS_DIVIDEND =
		WORD_WIDTH'(MS_PER_S) << (WORD_WIDTH - MS_DIV_BITS);

	localparam logic [CFG_WIDTH-1:0] WINDOW_LENGTH_RESET = CFG_WIDTH'(500);
	localparam logic [CFG_WIDTH-1:0] RATE_LIMIT_RESET    = CFG_WIDTH'(1000);

	localparam logic REG_WINDOW_LENGTH = 1'b0;
	localparam logic REG_RATE_LIMIT    = 1'b1;

	typedef struct packed {
		logic                      start;
		logic [DIV_STEP_WIDTH-1:0] steps;
	} div_ctl_t;

endpackage

[hdl/frame_rate_meter_core.sv]
// Frame rate meter top level: sequencer, window state and output register.
// Depends on frm_pkg, frm_serial_acc and frm_divider.
//
// One item per frame timestamp. An item runs through the bit-serial
// subtract/accumulate pass (one bit per cycle), then the 10-step division
// of 1000 by the delta unless the delta is zero, and, on frames that publish
// a new average, the 32-step division of the rate sum by the frame count on
// the same shared divider. A new item is accepted only once the last one has
// left the sequencer. A stalled output holds the finished item until the
// output register is free. The output register lets the next item be
// accepted while a result waits.
module frame_rate_meter_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [frm_pkg::CFG_WIDTH-1:0]  cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [frm_pkg::WORD_WIDTH-1:0] timestamp_ms,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [frm_pkg::WORD_WIDTH-1:0] delta_ms,
	output logic [frm_pkg::RATE_WIDTH-1:0] frame_rate,
	output logic                           rate_updated
);
	import frm_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SERIAL,
		ST_DIV_RATE,
		ST_ACCUM,
		ST_DIV_AVG,
		ST_FINISH
	} state_t;

	state_t                state_q;
	logic [CFG_WIDTH-1:0]  wl_q, rl_q;
	logic [WORD_WIDTH-1:0] prev_q, window_q, sum_q, count_q;
	logic [RATE_WIDTH-1:0] pub_q, rate_q;
	logic                  upd_q;
	logic                  out_valid_q, out_upd_q;
	logic [WORD_WIDTH-1:0] out_delta_q;
	logic [RATE_WIDTH-1:0] out_rate_q;

	logic                  acc_start, acc_done;
	logic [WORD_WIDTH-1:0] acc_delta, acc_window, acc_count;
	div_ctl_t              div_ctl;
	logic [WORD_WIDTH-1:0] div_dividend, div_divisor, div_quot;
	logic                  div_busy, div_done;

	logic [WORD_WIDTH:0]   sum_ext;
	logic [WORD_WIDTH-1:0] sum_new;
	logic                  publish, out_free;
	logic [RATE_WIDTH-1:0] avg_clamp;

	assign acc_start = (state_q == ST_IDLE) && in_valid;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		sum_ext   = {1'b0, sum_q} + {{(WORD_WIDTH + 1 - RATE_WIDTH){1'b0}}, rate_q};
		sum_new   = sum_ext[WORD_WIDTH] ? '1 : sum_ext[WORD_WIDTH-1:0];
		publish   = window_q >= WORD_WIDTH'(wl_q);
		avg_clamp = (div_quot >= WORD_WIDTH'(rl_q)) ? rl_q : div_quot[RATE_WIDTH-1:0];
	end

	always_comb begin
		div_ctl.start = 1'b0;
		div_ctl.steps = DIV_STEP_WIDTH'(MS_DIV_BITS);
		div_dividend  = MS_DIVIDEND;
		div_divisor   = acc_delta;
		case (state_q)
			ST_SERIAL: begin
				div_ctl.start = acc_done && (acc_delta != '0);
			end
			ST_ACCUM: begin
				div_ctl.start = publish;
				div_ctl.steps = DIV_STEP_WIDTH'(WORD_WIDTH);
				div_dividend  = sum_new;
				div_divisor   = count_q;
			end
			default: begin
				div_ctl.start = 1'b0;
			end
		endcase
	end

	frm_serial_acc u_acc (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (acc_start),
		.timestamp  (timestamp_ms),
		.prev       (prev_q),
		.window_in  (window_q),
		.count_in   (count_q),
		.delta      (acc_delta),
		.window_out (acc_window),
		.count_out  (acc_count),
		.done       (acc_done)
	);

	frm_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quot),
		.busy     (div_busy),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q <= WINDOW_LENGTH_RESET;
			rl_q <= RATE_LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW_LENGTH: wl_q <= cfg_data;
				REG_RATE_LIMIT:    rl_q <= cfg_data;
				default:           wl_q <= wl_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_q      <= '0;
			window_q    <= '0;
			sum_q       <= '0;
			count_q     <= '0;
			pub_q       <= '0;
			rate_q      <= '0;
			upd_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_delta_q <= '0;
			out_rate_q  <= '0;
			out_upd_q   <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						prev_q  <= timestamp_ms;
						state_q <= ST_SERIAL;
					end
				end
				ST_SERIAL: begin
					if (acc_done) begin
						window_q <= acc_window;
						count_q  <= acc_count;
						upd_q    <= 1'b0;
						if (acc_delta == '0) begin
							rate_q  <= rl_q;
							state_q <= ST_ACCUM;
						end else begin
							state_q <= ST_DIV_RATE;
						end
					end
				end
				ST_DIV_RATE: begin
					if (div_done) begin
						rate_q  <= div_quot[RATE_WIDTH-1:0];
						state_q <= ST_ACCUM;
					end
				end
				ST_ACCUM: begin
					sum_q   <= sum_new;
					state_q <= publish ? ST_DIV_AVG : ST_FINISH;
				end
				ST_DIV_AVG: begin
					if (div_done) begin
						pub_q    <= avg_clamp;
						window_q <= window_q - WORD_WIDTH'(wl_q);
						sum_q    <= '0;
						count_q  <= '0;
						upd_q    <= 1'b1;
						state_q  <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_delta_q <= acc_delta;
						out_rate_q  <= pub_q;
						out_upd_q   <= upd_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign delta_ms     = out_delta_q;
	assign frame_rate   = out_rate_q;
	assign rate_updated = out_upd_q;

`ifndef ASSERT_OFF
	a_accept_starts_serial: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_SERIAL))
		else $error("accepted item did not start the serial pass");

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_ctl.start |-> !div_busy)
		else $error("divider restarted while busy");

	a_finish_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && out_free) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("finished item not loaded into output register");
`endif

endmodule

[hdl/frm_serial_acc.sv]
// Bit-serial front end: wrapped timestamp difference, saturating window time
// and saturating frame count, one bit per cycle, LSB first. Uses frm_pkg.
module frm_serial_acc (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [frm_pkg::WORD_WIDTH-1:0]  timestamp,
	input  logic [frm_pkg::WORD_WIDTH-1:0]  prev,
	input  logic [frm_pkg::WORD_WIDTH-1:0]  window_in,
	input  logic [frm_pkg::WORD_WIDTH-1:0]  count_in,
	output logic [frm_pkg::WORD_WIDTH-1:0]  delta,
	output logic [frm_pkg::WORD_WIDTH-1:0]  window_out,
	output logic [frm_pkg::WORD_WIDTH-1:0]  count_out,
	output logic                            done
);
	import frm_pkg::*;

	logic [WORD_WIDTH-1:0]    a_q, b_q, w_q, c_q, d_q;
	logic                     borrow_q, cw_q, cc_q;
	logic [ACC_CNT_WIDTH-1:0] cnt_q;
	logic                     busy_q, done_q;
	logic                     d_bit, borrow_n, w_bit, cw_n, c_bit, cc_n;

	always_comb begin
		d_bit    = a_q[0] ^ b_q[0] ^ borrow_q;
		borrow_n = (~a_q[0] & b_q[0]) | (~(a_q[0] ^ b_q[0]) & borrow_q);
		w_bit    = w_q[0] ^ d_bit ^ cw_q;
		cw_n     = (w_q[0] & d_bit) | (w_q[0] & cw_q) | (d_bit & cw_q);
		c_bit    = c_q[0] ^ cc_q;
		cc_n     = c_q[0] & cc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == ACC_CNT_WIDTH'(WORD_WIDTH - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q      <= timestamp;
			b_q      <= prev;
			w_q      <= window_in;
			c_q      <= count_in;
			borrow_q <= 1'b0;
			cw_q     <= 1'b0;
			cc_q     <= 1'b1;
		end else if (busy_q) begin
			a_q      <= {1'b0, a_q[WORD_WIDTH-1:1]};
			b_q      <= {1'b0, b_q[WORD_WIDTH-1:1]};
			d_q      <= {d_bit, d_q[WORD_WIDTH-1:1]};
			w_q      <= {w_bit, w_q[WORD_WIDTH-1:1]};
			c_q      <= {c_bit, c_q[WORD_WIDTH-1:1]};
			borrow_q <= borrow_n;
			cw_q     <= cw_n;
			cc_q     <= cc_n;
		end
	end

	assign delta      = d_q;
	assign window_out = cw_q ? '1 : w_q;
	assign count_out  = cc_q ? '1 : c_q;
	assign done       = done_q;

endmodule

[hdl/frm_divider.sv]
// Shared restoring divider, one quotient bit per cycle for a chosen number
// of steps; the dividend comes in left-aligned. Uses frm_pkg.
module frm_divider (
	input  logic                           clk,
	input  logic                           arst_n,
	input  frm_pkg::div_ctl_t              ctl,
	input  logic [frm_pkg::WORD_WIDTH-1:0] dividend,
	input  logic [frm_pkg::WORD_WIDTH-1:0] divisor,
	output logic [frm_pkg::WORD_WIDTH-1:0] quotient,
	output logic                           busy,
	output logic                           done
);
	import frm_pkg::*;

	logic [WORD_WIDTH-1:0]     dq_q, rem_q, div_q;
	logic [DIV_STEP_WIDTH-1:0] cnt_q;
	logic                      busy_q, done_q;
	logic [WORD_WIDTH:0]       shifted, trial;
	logic                      ge;

	always_comb begin
		shifted = {rem_q, dq_q[WORD_WIDTH-1]};
		trial   = shifted - {1'b0, div_q};
		ge      = shifted >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= ctl.steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_STEP_WIDTH'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[WORD_WIDTH-2:0], ge};
			rem_q <= ge ? trial[WORD_WIDTH-1:0] : shifted[WORD_WIDTH-1:0];
		end
	end

	assign quotient = dq_q;
	assign busy     = busy_q;
	assign done     = done_q;

endmodule

[dv/frame_rate_meter_core_tb.sv]
`timescale 1ns / 100ps
// Testbench for frame_rate_meter_core: random and directed frame timestamps,
// predicted frame by frame and checked against every result item.
// Depends on frm_pkg and the frame_rate_meter_core RTL.
module frame_rate_meter_core_tb;

	localparam int CLK_HALF    = 4;
	localparam int RESET_LEN   = 11;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_LEN  = 100;
	localparam int REPORT_MAX  = 10;

	localparam logic [31:0] OPENING_STAMPS [12] = '{
		32'd0, 32'd0, 32'd1, 32'd3, 32'd6, 32'd1006,
		32'd2007, 32'd2007, 32'd2007, 32'd2017, 32'd2517, 32'd2518
	};
	localparam logic [31:0] LONG_GAP_STAMPS [8] = '{
		32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
		32'hFFFF_FFFE, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555
	};

	typedef struct {
		logic [31:0] delta;
		logic [15:0] rate;
		logic        updated;
	} frame_result_t;

	class rate_scoreboard;
		logic [15:0]   window_len;
		logic [15:0]   rate_cap;
		logic [31:0]   last_stamp;
		logic [31:0]   window_ms;
		logic [31:0]   rate_total;
		logic [31:0]   frame_total;
		logic [15:0]   shown_rate;
		frame_result_t expected_q [$];
		int            errors;
		int            results_seen;

		function new();
			window_len   = frm_pkg::WINDOW_LENGTH_RESET;
			rate_cap     = frm_pkg::RATE_LIMIT_RESET;
			last_stamp   = '0;
			window_ms    = '0;
			rate_total   = '0;
			frame_total  = '0;
			shown_rate   = '0;
			errors       = 0;
			results_seen = 0;
		endfunction

		function void set_reg(logic idx, logic [15:0] value);
			if (idx == frm_pkg::REG_WINDOW_LENGTH)
				window_len = value;
			else
				rate_cap = value;
		endfunction

		function logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
			logic [32:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[32] ? '1 : s[31:0];
		endfunction

		function void note_frame(logic [31:0] stamp);
			logic [31:0]   gap;
			logic [31:0]   per_frame;
			logic [31:0]   avg;
			frame_result_t exp_r;
			gap        = stamp - last_stamp;
			last_stamp = stamp;
			per_frame  = (gap == 0) ? 32'(rate_cap) : 32'd1000 / gap;
			window_ms   = sat_add(window_ms, gap);
			rate_total  = sat_add(rate_total, per_frame);
			frame_total = sat_add(frame_total, 32'd1);
			exp_r.updated = 1'b0;
			if (window_ms >= 32'(window_len)) begin
				avg = rate_total / frame_total;
				if (avg >= 32'(rate_cap))
					avg = 32'(rate_cap);
				shown_rate    = avg[15:0];
				window_ms     = window_ms - 32'(window_len);
				rate_total    = '0;
				frame_total   = '0;
				exp_r.updated = 1'b1;
			end
			exp_r.delta = gap;
			exp_r.rate  = shown_rate;
			expected_q.push_back(exp_r);
		endfunction

		function void check_frame(logic [31:0] delta, logic [15:0] rate, logic updated);
			frame_result_t exp_r;
			results_seen++;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("result %0d: unexpected item delta %0d rate %0d updated %0b",
						results_seen, delta, rate, updated);
				return;
			end
			exp_r = expected_q.pop_front();
			if (delta !== exp_r.delta || rate !== exp_r.rate || updated !== exp_r.updated) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("result %0d: expected delta %0d rate %0d updated %0b, got %0d %0d %0b",
						results_seen, exp_r.delta, exp_r.rate, exp_r.updated,
						delta, rate, updated);
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic                           cfg_index;
	logic [frm_pkg::CFG_WIDTH-1:0]  cfg_data;
	logic                           in_valid;
	logic                           in_stall;
	logic [frm_pkg::WORD_WIDTH-1:0] timestamp_ms;
	logic                           out_valid;
	logic                           out_stall;
	logic [frm_pkg::WORD_WIDTH-1:0] delta_ms;
	logic [frm_pkg::RATE_WIDTH-1:0] frame_rate;
	logic                           rate_updated;

	rate_scoreboard sb = new();
	int             send_idle_pct;
	int             recv_stall_pct;
	int             hold_left;
	int             cycle_cnt;
	logic [31:0]    last_ts;

	frame_rate_meter_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.timestamp_ms (timestamp_ms),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.delta_ms     (delta_ms),
		.frame_rate   (frame_rate),
		.rate_updated (rate_updated)
	);

	always #CLK_HALF clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// hold off for the requested stretch, then stall at random
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else
			out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_frame(delta_ms, frame_rate, rate_updated);
	end

	task automatic write_reg(input logic idx, input logic [15:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		sb.set_reg(idx, value);
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic send_item(input logic [31:0] stamp);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		timestamp_ms <= stamp;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_frame(stamp);
		last_ts = stamp;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	function automatic logic [31:0] next_stamp(input bit jumps);
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 8)
			return last_ts;
		if (pick < 70)
			return last_ts + $urandom_range(1, 40);
		if (pick < 88 || !jumps)
			return last_ts + $urandom_range(41, 1500);
		if (pick < 95)
			return $urandom;
		return last_ts - $urandom_range(1, 1000);
	endfunction

	task automatic run_frames(input int count, input bit jumps);
		repeat (count)
			send_item(next_stamp(jumps));
	endtask

	task automatic run_phase(input logic [15:0] wl, input logic [15:0] rl,
			input int send_pct, input int recv_pct, input int hold,
			input int count, input bit jumps);
		write_reg(frm_pkg::REG_WINDOW_LENGTH, wl);
		write_reg(frm_pkg::REG_RATE_LIMIT, rl);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		hold_left      = hold;
		if (jumps)
			foreach (LONG_GAP_STAMPS[i])
				send_item(LONG_GAP_STAMPS[i]);
		run_frames(count, jumps);
		drain();
	endtask

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = frm_pkg::REG_WINDOW_LENGTH;
		cfg_data       = '0;
		in_valid       = 1'b0;
		timestamp_ms   = '0;
		out_stall      = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_left      = 0;
		cycle_cnt      = 0;
		last_ts        = '0;
		repeat (RESET_LEN) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (OPENING_STAMPS[i])
			send_item(OPENING_STAMPS[i]);
		run_frames(100, 1'b0);
		drain();

		run_phase(16'd1, 16'd65535, 81, 0, 0, 100, 1'b0);
		run_phase(16'd65535, 16'd1, 0, 81, 0, 100, 1'b0);
		run_phase(16'd100, 16'd60, 27, 27, 600, 120, 1'b0);
		run_phase(16'($urandom_range(1, 2000)), 16'($urandom_range(1, 65535)),
			0, 81, 0, 120, 1'b0);
		run_phase(16'd500, 16'd1000, 27, 27, 0, 140, 1'b1);

		repeat (SETTLE_LEN) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
